### src/bra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared sizes, operation codes, controller states and the scan result type.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int MAX_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int NWORDS    = MAX_BITS / WORD_BITS;

  localparam int POS_W  = 12;
  localparam int LEN_W  = 13;
  localparam int WADR_W = 6;
  localparam int BIT_W  = 6;
  localparam int CNT_W  = 7;

  localparam logic [LEN_W-1:0] SIZE_RESET = LEN_W'(MAX_BITS);

  typedef enum logic [2:0] {
    KIND_FIND_CLR     = 3'd0,
    KIND_FIND_CLR_SET = 3'd1,
    KIND_FIND_SET     = 3'd2,
    KIND_FIND_SET_CLR = 3'd3,
    KIND_SET_RANGE    = 3'd4,
    KIND_CLR_RANGE    = 3'd5,
    KIND_SET_ALL      = 3'd6,
    KIND_CLR_ALL      = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREAD,
    ST_FEVAL,
    ST_WREAD,
    ST_WWRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] run_next;
  } scan_res_t;

endpackage : bra_pkg
`default_nettype wire

### src/bra_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocator request per beat.
// ----------------------------------------------------------------------------
interface bra_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [11:0] start_or_hint;
  logic [12:0] length;

  modport source (output valid, kind, start_or_hint, length, input ready);
  modport sink   (input valid, kind, start_or_hint, length, output ready);
endinterface : bra_req_if
`default_nettype wire

### src/bra_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one allocator result per beat.
// ----------------------------------------------------------------------------
interface bra_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [11:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface : bra_rsp_if
`default_nettype wire

### src/bra_word_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap word store
// Synchronous word memory with a registered read port and per-word valid
// bits so that every word reads as zero until it is first written.
// ----------------------------------------------------------------------------
module bra_word_store (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rd_en,
  input  wire logic [bra_pkg::WADR_W-1:0]     rd_addr,
  output logic      [bra_pkg::WORD_BITS-1:0]  rd_data,
  input  wire logic                           wr_en,
  input  wire logic [bra_pkg::WADR_W-1:0]     wr_addr,
  input  wire logic [bra_pkg::WORD_BITS-1:0]  wr_data
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule : bra_word_store
`default_nettype wire

### src/bra_run_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run scanner
// Examines one bitmap word against the carried-in run and reports the lowest
// start of a run of the requested length that completes in this word.
// ----------------------------------------------------------------------------
module bra_run_scan (
  input  wire logic [bra_pkg::WORD_BITS-1:0] data,
  input  wire logic                          want,
  input  wire logic [bra_pkg::WADR_W-1:0]    word_idx,
  input  wire logic [bra_pkg::POS_W-1:0]     first,
  input  wire logic [bra_pkg::POS_W-1:0]     last,
  input  wire logic [bra_pkg::LEN_W-1:0]     run_in,
  input  wire logic [bra_pkg::LEN_W-1:0]     len,
  output bra_pkg::scan_res_t                 res
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] match;
  logic [WORD_BITS-1:0] runs [BIT_W+1];
  logic [WORD_BITS-1:0] win;
  logic [WORD_BITS-1:0] starts;
  logic [2:0]           lg;
  logic [BIT_W-1:0]     shamt;
  logic [CNT_W-1:0]     lead;
  logic [CNT_W-1:0]     trail;
  logic [BIT_W-1:0]     first_start;
  logic                 any_start;
  logic                 carry_hit;
  logic [LEN_W:0]       carry_sum;
  logic [LEN_W-1:0]     base;

  assign lo_mask = (word_idx == first[POS_W-1:BIT_W]) ? ('1 << first[BIT_W-1:0]) : '1;
  assign hi_mask = (word_idx == last[POS_W-1:BIT_W])
                   ? ('1 >> (BIT_W'(WORD_BITS - 1) - last[BIT_W-1:0])) : '1;
  assign match   = (want ? data : ~data) & lo_mask & hi_mask;

  // runs[k] marks every bit that opens a run of 2**k matching bits.
  always_comb begin
    runs[0] = match;
    for (int k = 0; k < BIT_W; k++) begin
      runs[k+1] = runs[k] & (runs[k] >> (1 << k));
    end
  end

  // Two windows of 2**lg bits, offset by len - 2**lg, cover exactly len bits.
  always_comb begin
    lg = 3'd0;
    for (int k = 0; k <= BIT_W; k++) begin
      if (len[k]) begin
        lg = 3'(k);
      end
    end
    shamt  = BIT_W'(len - (LEN_W'(1) << lg));
    win    = runs[lg];
    starts = (len == '0 || len > LEN_W'(WORD_BITS)) ? '0 : (win & (win >> shamt));
  end

  always_comb begin
    trail       = CNT_W'(WORD_BITS);
    lead        = CNT_W'(WORD_BITS);
    first_start = '0;
    any_start   = |starts;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!match[i]) begin
        trail = CNT_W'(i);
      end
      if (starts[i]) begin
        first_start = BIT_W'(i);
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!match[i]) begin
        lead = CNT_W'(WORD_BITS - 1 - i);
      end
    end
  end

  // A run carried in from earlier words starts before this word and wins.
  assign carry_sum = {1'b0, run_in} + (LEN_W+1)'(trail);
  assign carry_hit = (run_in != '0) && (carry_sum >= {1'b0, len});
  assign base      = {1'b0, word_idx, {BIT_W{1'b0}}};

  always_comb begin
    res.hit      = carry_hit || any_start;
    res.pos      = carry_hit ? POS_W'(base - run_in) : {word_idx, first_start};
    res.run_next = (&match) ? (run_in + LEN_W'(WORD_BITS)) : LEN_W'(lead);
  end

endmodule : bra_run_scan
`default_nettype wire

### src/bitmap_run_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap run allocator
// Finds, sets and clears runs of bits in a 4096-bit bitmap held in memory.
// ----------------------------------------------------------------------------
// One request is handled at a time; req.ready is high only while the block is
// idle, and each request yields exactly one response beat. The bitmap sits in
// a memory of 64 words of 64 bits with one read and one write port, and every
// word visit is a registered read followed by an evaluate or a write back. A
// search visits the words from the hint to the end of the bitmap and then, for
// a nonzero hint, from word 0 to the hint. A find-and-flip then reads and
// writes back each word the run spans; a range fill does the same for each
// word touched, so set-all and clear-all of a full bitmap visit all 64 words.
// Zero-length searches, over-length searches and empty ranges go straight to
// the response without a memory visit. No clearing pass is needed after reset:
// per-word valid bits read as zero.
module bitmap_run_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  bra_req_if.sink          req,
  bra_rsp_if.source        rsp
);
  import bra_pkg::*;

  state_t state, state_next;

  logic [LEN_W-1:0]  size_reg;
  logic [LEN_W-1:0]  size_eff;
  logic [2:0]        kind_q;
  logic              want;
  logic              fill_val;
  logic              second_pass;
  logic [POS_W-1:0]  hint_q;
  logic [LEN_W-1:0]  len_q;
  logic [POS_W-1:0]  first_q;
  logic [POS_W-1:0]  last_q;
  logic [WADR_W-1:0] word_q;
  logic [LEN_W-1:0]  run_q;
  logic              res_found;
  logic [POS_W-1:0]  res_pos;

  logic              in_beat;
  logic              out_beat;
  logic              rd_en;
  logic              wr_en;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] fill_mask;
  scan_res_t         scan;

  // Request decode
  logic [POS_W-1:0]  hint_eff;
  logic [LEN_W:0]    rng_end;
  logic [LEN_W-1:0]  rng_clip;
  logic              last_word;
  logic              flip_kind;

  assign size_eff  = (size_reg > SIZE_RESET) ? SIZE_RESET : size_reg;
  assign hint_eff  = ({1'b0, req.start_or_hint} < size_eff) ? req.start_or_hint : '0;
  assign rng_end   = {2'b00, req.start_or_hint} + {1'b0, req.length};
  assign rng_clip  = (rng_end > {1'b0, size_eff}) ? size_eff : LEN_W'(rng_end);
  assign last_word = (word_q == last_q[POS_W-1:BIT_W]);
  assign flip_kind = (kind_q == KIND_FIND_CLR_SET) || (kind_q == KIND_FIND_SET_CLR);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_reg <= cfg_wr_data;
    end
  end

  bra_word_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (word_q),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_q),
    .wr_data (wr_data)
  );

  bra_run_scan u_scan (
    .data     (rd_data),
    .want     (want),
    .word_idx (word_q),
    .first    (first_q),
    .last     (last_q),
    .run_in   (run_q),
    .len      (len_q),
    .res      (scan)
  );

  assign fill_mask =
      ((word_q == first_q[POS_W-1:BIT_W]) ? ('1 << first_q[BIT_W-1:0]) : '1) &
      ((word_q == last_q[POS_W-1:BIT_W])
       ? ('1 >> (BIT_W'(WORD_BITS - 1) - last_q[BIT_W-1:0])) : '1);
  assign wr_data = fill_val ? (rd_data | fill_mask) : (rd_data & ~fill_mask);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          priority if (!req.kind[2]) begin
            state_next = (req.length > size_eff || req.length == '0) ? ST_DONE : ST_FREAD;
          end else if (!req.kind[1]) begin
            state_next = ({1'b0, req.start_or_hint} >= size_eff || req.length == '0)
                         ? ST_DONE : ST_WREAD;
          end else begin
            state_next = (size_eff == '0) ? ST_DONE : ST_WREAD;
          end
        end
      end
      ST_FREAD: state_next = ST_FEVAL;
      ST_FEVAL: begin
        priority if (scan.hit) begin
          state_next = flip_kind ? ST_WREAD : ST_DONE;
        end else if (last_word && !second_pass) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FREAD;
        end
      end
      ST_WREAD:  state_next = ST_WWRITE;
      ST_WWRITE: state_next = last_word ? ST_DONE : ST_WREAD;
      ST_DONE:   state_next = rsp.ready ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs
  always_comb begin
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    unique case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_FREAD:  rd_en     = 1'b1;
      ST_WREAD:  rd_en     = 1'b1;
      ST_WWRITE: wr_en     = 1'b1;
      ST_DONE:   rsp.valid = 1'b1;
      default:   ;
    endcase
  end

  assign in_beat      = req.valid && req.ready;
  assign out_beat     = rsp.valid && rsp.ready;
  assign rsp.found    = res_found;
  assign rsp.position = res_pos;

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          kind_q   <= req.kind;
          want     <= req.kind[1];
          len_q    <= req.length;
          run_q    <= '0;
          priority if (!req.kind[2]) begin
            hint_q      <= hint_eff;
            first_q     <= hint_eff;
            last_q      <= POS_W'(size_eff - LEN_W'(1));
            word_q      <= hint_eff[POS_W-1:BIT_W];
            second_pass <= (hint_eff != '0);
            fill_val    <= ~req.kind[1];
            res_found   <= !(req.length > size_eff);
            res_pos     <= (req.length > size_eff) ? '0 : hint_eff;
          end else if (!req.kind[1]) begin
            first_q   <= req.start_or_hint;
            last_q    <= POS_W'(rng_clip - LEN_W'(1));
            word_q    <= req.start_or_hint[POS_W-1:BIT_W];
            fill_val  <= ~req.kind[0];
            res_found <= 1'b1;
            res_pos   <= req.start_or_hint;
          end else begin
            first_q   <= '0;
            last_q    <= POS_W'(size_eff - LEN_W'(1));
            word_q    <= '0;
            fill_val  <= ~req.kind[0];
            res_found <= 1'b1;
            res_pos   <= '0;
          end
        end
      end
      ST_FEVAL: begin
        priority if (scan.hit) begin
          res_found <= 1'b1;
          res_pos   <= scan.pos;
          first_q   <= scan.pos;
          last_q    <= POS_W'({2'b00, scan.pos} + {1'b0, len_q} - (POS_W+1)'(1));
          word_q    <= scan.pos[POS_W-1:BIT_W];
        end else if (last_word && second_pass) begin
          // Wrap to the pass whose runs must end before the hint.
          first_q     <= '0;
          last_q      <= hint_q - POS_W'(1);
          word_q      <= '0;
          run_q       <= '0;
          second_pass <= 1'b0;
        end else if (last_word) begin
          res_found <= 1'b0;
          res_pos   <= '0;
        end else begin
          word_q <= word_q + WADR_W'(1);
          run_q  <= scan.run_next;
        end
      end
      ST_WWRITE: begin
        if (!last_word) begin
          word_q <= word_q + WADR_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Assertions
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request accepted while a response is pending");

  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.position == '0))
    else $error("failed search reports a nonzero position");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !req.ready)
    else $error("second request taken before the first completed");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !out_beat) |=> (rsp.valid && $stable(rsp.position)))
    else $error("response changed while stalled");

endmodule : bitmap_run_allocator
`default_nettype wire

### bench/bitmap_run_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run allocator checker
// Watches the request, response and configuration ports, keeps its own copy
// of the bitmap and the size, and compares every response beat in order.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  bra_req_if.sink     req_mon,
  bra_rsp_if.sink     rsp_mon,
  output int          errors,
  output int          pending
);
  import bra_pkg::*;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  logic [MAX_BITS-1:0] shadow_map;
  logic [LEN_W-1:0]    shadow_size;
  answer_t             answer_q[$];

  assign pending = answer_q.size();

  function automatic int used_bits();
    return (shadow_size > MAX_BITS) ? MAX_BITS : int'(shadow_size);
  endfunction

  function automatic void fill_bits(int first, int count, logic v);
    int sz;
    sz = used_bits();
    if (first >= sz) return;
    if (count > sz - first) count = sz - first;
    for (int i = 0; i < count; i++) shadow_map[first + i] = v;
  endfunction

  // Lowest start in [from, limit-len] of a run of len bits equal to want.
  function automatic bit scan_span(int from, int limit, int len, logic want,
                                   output int pos);
    int run;
    run = 0;
    pos = 0;
    for (int i = from; i < limit; i++) begin
      run = (shadow_map[i] == want) ? run + 1 : 0;
      if (run == len) begin
        pos = i + 1 - len;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic answer_t allocate(kind_t kind, int start, int len);
    answer_t a;
    int sz, hint, pos;
    bit ok;
    logic want;
    sz = used_bits();
    a = '0;
    case (kind)
      KIND_FIND_CLR, KIND_FIND_CLR_SET, KIND_FIND_SET, KIND_FIND_SET_CLR: begin
        want = (kind == KIND_FIND_SET || kind == KIND_FIND_SET_CLR);
        hint = (start >= sz) ? 0 : start;
        pos = 0;
        if (len > sz) ok = 0;
        else if (len == 0) begin
          ok = 1;
          pos = hint;
        end else begin
          ok = scan_span(hint, sz, len, want, pos);
          if (!ok && hint != 0) ok = scan_span(0, hint, len, want, pos);
        end
        if (!ok) pos = 0;
        else if (kind == KIND_FIND_CLR_SET || kind == KIND_FIND_SET_CLR)
          fill_bits(pos, len, !want);
        a.found = ok;
        a.position = POS_W'(pos);
      end
      KIND_SET_RANGE, KIND_CLR_RANGE: begin
        fill_bits(start, len, kind == KIND_SET_RANGE);
        a.found = 1;
        a.position = POS_W'(start);
      end
      KIND_SET_ALL: begin
        fill_bits(0, sz, 1'b1);
        a.found = 1;
      end
      default: begin
        fill_bits(0, sz, 1'b0);
        a.found = 1;
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, exp_a;
    if (rst) begin
      shadow_map  = '0;
      shadow_size = SIZE_RESET;
      answer_q.delete();
      errors <= 0;
    end else begin
      if (cfg_wr_en) shadow_size = cfg_wr_data;
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.found = rsp_mon.found;
        got.position = rsp_mon.position;
        if (answer_q.size() == 0) begin
          $error("response beat with no request outstanding");
          errors <= errors + 1;
        end else begin
          exp_a = answer_q.pop_front();
          if (got.found !== exp_a.found) begin
            $error("found: expected %0d, got %0d", exp_a.found, got.found);
            errors <= errors + 1;
          end else if (got.position !== exp_a.position) begin
            $error("position: expected %0d, got %0d", exp_a.position, got.position);
            errors <= errors + 1;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        answer_q.push_back(allocate(kind_t'(req_mon.kind), int'(req_mon.start_or_hint),
                                    int'(req_mon.length)));
    end
  end

endmodule

### bench/bitmap_run_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run allocator testbench
// Drives directed and random requests across several bitmap sizes, with
// bursty requests and a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_test;
  import bra_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [12:0] cfg_wr_data = '0;
  int          errors, pending;
  bit          hold_long = 0;
  logic [12:0] cur_size = 13'd4096;

  bra_req_if req ();
  bra_rsp_if rsp ();

  bitmap_run_allocator dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req(req.sink), .rsp(rsp.source)
  );

  bitmap_run_allocator_checker checker_i (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req_mon(req.sink), .rsp_mon(rsp.sink), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 0;
    req.kind = '0;
    req.start_or_hint = '0;
    req.length = '0;
    rsp.ready = 0;
  end

  // Receiver: stalls on its own pattern, plus one long hold-off on request.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        rsp.ready <= 0;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
        hold_long = 0;
      end
      rsp.ready <= ($urandom_range(0, 3) != 0) || (($urandom & 32'h3f) == 0);
    end
  end

  int gap_left = 0;

  // Offers one beat; between beats the sender may pause for a random gap.
  task automatic send(kind_t k, logic [11:0] s, logic [12:0] n);
    req.valid <= 1;
    req.kind <= k;
    req.start_or_hint <= s;
    req.length <= n;
    do @(posedge clk); while (!(req.valid && req.ready));
    if (gap_left == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
    end else gap_left--;
  endtask

  task automatic drain_and_size(logic [12:0] sz);
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= sz;
    cur_size = sz;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  // Mostly small runs inside the current size, with some wild values.
  task automatic random_item();
    kind_t k;
    int lim;
    logic [11:0] s;
    logic [12:0] n;
    lim = (cur_size == 0) ? 1 : ((cur_size > 4096) ? 4096 : int'(cur_size));
    k = kind_t'($urandom_range(0, 7));
    if ((k == KIND_SET_ALL || k == KIND_CLR_ALL) && $urandom_range(0, 3) != 0)
      k = kind_t'($urandom_range(0, 5));
    s = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, lim - 1));
    case ($urandom_range(0, 9))
      0: n = 13'($urandom);
      1: n = 13'($urandom_range(0, lim));
      2, 3: n = 13'($urandom_range(0, 200));
      default: n = 13'($urandom_range(0, 12));
    endcase
    send(k, s, n);
  endtask

  initial begin
    logic [12:0] sizes[6];
    sizes = '{13'd4096, 13'd1, 13'd100, 13'd8191, 13'd0, 13'd640};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, every kind, special cases.
    send(KIND_FIND_CLR, 12'd0, 13'd0);
    send(KIND_FIND_CLR, 12'd4095, 13'd4096);
    send(KIND_FIND_SET, 12'd5, 13'd1);
    send(KIND_FIND_CLR, 12'd0, 13'd4097);
    send(KIND_FIND_CLR, 12'd0, 13'h1fff);
    send(KIND_SET_RANGE, 12'd4090, 13'd100);
    send(KIND_FIND_CLR_SET, 12'd4000, 13'd90);
    send(KIND_FIND_CLR_SET, 12'd4000, 13'd64);
    send(KIND_FIND_SET_CLR, 12'd1, 13'd6);
    send(KIND_CLR_RANGE, 12'd4095, 13'd1);
    send(KIND_FIND_CLR, 12'd4095, 13'd1);
    send(KIND_SET_ALL, 12'hfff, 13'h1fff);
    send(KIND_FIND_SET, 12'hfff, 13'd4096);
    send(KIND_FIND_SET_CLR, 12'd63, 13'd130);
    send(KIND_FIND_CLR, 12'd100, 13'd131);
    send(KIND_CLR_ALL, 12'd0, 13'd0);
    send(KIND_FIND_SET, 12'd0, 13'd1);
    send(KIND_SET_RANGE, 12'd0, 13'd0);
    send(KIND_SET_RANGE, 12'd0, 13'h1fff);
    send(KIND_FIND_CLR_SET, 12'd2, 13'd5);
    drain_and_size(13'd50);
    send(KIND_FIND_CLR, 12'd60, 13'd10);
    send(KIND_FIND_SET, 12'd20, 13'd50);
    foreach (sizes[p]) begin
      drain_and_size(sizes[p]);
      if (p == 0) hold_long = 1;
      repeat (270) random_item();
    end
    drain_and_size(13'd4096);
    repeat (30) random_item();
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("PASS bitmap_run_allocator");
    else $display("FAIL bitmap_run_allocator");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL bitmap_run_allocator");
    $finish;
  end

endmodule
